[rtl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon classifier package
// Shared types, codes and default sizes for the polygon classifier.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Default sizes of the vertex store and the coordinates.
  localparam int unsigned MaxVerticesDefault = 1024;
  localparam int unsigned CoordBitsDefault   = 32;

  // Widths of the fixed port fields.
  localparam int unsigned IndexBits  = 10;
  localparam int unsigned FieldBits  = 32;
  localparam int unsigned CountBits  = 11;
  localparam int unsigned LocBits    = 2;
  localparam int unsigned InDataBits = 80;
  localparam int unsigned OutDataBits = 8;

  // Request kinds carried in tuser.
  localparam logic ReqVertex = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  // Classification codes.
  localparam logic [LocBits-1:0] LocOutside  = 2'd0;
  localparam logic [LocBits-1:0] LocInside   = 2'd1;
  localparam logic [LocBits-1:0] LocBoundary = 2'd2;

  // Reset value of the vertex count register.
  localparam logic [CountBits-1:0] CountReset = 11'd3;

  // Query sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDrain,
    StFinish
  } state_e;

endpackage

[rtl/point_in_polygon_classifier.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon classifier
// Classifies query points against a stored polygon by ray casting.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries requests. tuser selects the kind: a vertex write
//   stores tdata's point at vertex_index and gives no result; a query walks
//   the polygon and gives one location on the master stream.
//   The vertex count register is written through cfg_we_i/cfg_wdata_i; the user writes it only while the block
//   is idle, which the block itself does not enforce; zero counts as one vertex, larger counts saturate.
// Query walk:
//   The single read port of the vertex memory hands out one vertex per
//   cycle, n + 1 reads in all for n vertices, and a four-stage edge
//   pipeline (read, difference, multiply, sign test) follows it.
// Reset:
//   The sequencer returns to idle, the vertex count becomes three and the
//   output holds no result. Vertex memory contents are undefined until
//   written; no clearing pass runs.
// Stalls:
//   A finished result waits in the output register; new requests are still
//   taken. A query that finishes while that register is full waits for it.
// ----------------------------------------------------------------------------
module point_in_polygon_classifier #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MaxVerticesDefault,
  parameter int unsigned COORD_BITS   = pip_pkg::CoordBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: vertex_count.
  input  logic                              cfg_we_i,
  input  logic [pip_pkg::CountBits-1:0]     cfg_wdata_i,
  // Request stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: vertex_index [9:0], coord_x [41:10], coord_y [73:42], zero fill.
  input  logic [pip_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // tuser: req_type [0].
  input  logic                              s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: location [1:0], zero fill.
  output logic [pip_pkg::OutDataBits-1:0]   m_axis_tdata_o
);
  import pip_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  // Request fields.
  logic [IndexBits-1:0] in_index;
  logic [FieldBits-1:0] in_x;
  logic [FieldBits-1:0] in_y;
  assign in_index = s_axis_tdata_i[9:0];
  assign in_x     = s_axis_tdata_i[41:10];
  assign in_y     = s_axis_tdata_i[73:42];

  state_e state_q, state_d;
  logic   req_accept;
  logic   query_start;
  logic   vertex_wr;
  logic   rd_en;
  logic   out_load;

  logic [CountBits-1:0] vcount_q;
  logic [CW-1:0]        n_q;
  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        addr_full;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  logic signed [CB-1:0] px_q, py_q;

  // Pipeline valid and tag bits.
  logic v1_q, first1_q, v2_q, v3_q;

  // Vertex memory, {y, x} per entry, one read port with registered data.
  logic [2*CB-1:0] mem [MAX_VERTICES];
  logic [2*CB-1:0] rd_data_q;
  logic [2*CB-1:0] a_q;

  // Stage registers.
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic                 span2_q, left2_q, right2_q, up2_q;
  logic signed [PW-1:0] pc1_q, pc2_q, pd1_q, pd2_q;
  logic                 span3_q, left3_q, right3_q, up3_q;

  logic bnd_q, par_q;
  logic out_valid_q;
  logic [LocBits-1:0] loc_q;

  // Accepted request decode.
  assign req_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign query_start = req_accept && (s_axis_tuser_i == ReqQuery);
  assign vertex_wr   = req_accept && (s_axis_tuser_i == ReqVertex) &&
                       (32'(in_index) < 32'(MAX_VERTICES));
  assign wr_addr     = AW'(32'(in_index));

  // Effective vertex count: zero acts as one, large counts saturate.
  always_comb begin
    if (vcount_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(32'(vcount_q));
    end
  end

  // Read order: last vertex first, then vertex 0 up to the last one.
  assign addr_full = (cnt_q == '0) ? (n_q - CW'(1)) : (cnt_q - CW'(1));
  assign rd_addr   = addr_full[AW-1:0];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (query_start) begin
          state_d = StRead;
          cnt_d   = '0;
        end
      end
      StRead: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == n_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      StIdle:   s_axis_tready_o = 1'b1;
      StRead:   rd_en = 1'b1;
      StDrain:  ;
      StFinish: out_load = !out_valid_q || m_axis_tready_i;
      default:  ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      vcount_q    <= CountReset;
      v1_q        <= 1'b0;
      first1_q    <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      v1_q     <= rd_en;
      first1_q <= rd_en && (cnt_q == '0);
      v2_q     <= v1_q && !first1_q;
      v3_q     <= v2_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Vertex memory write and read.
  always_ff @(posedge clk_i) begin
    if (vertex_wr) begin
      mem[wr_addr] <= {in_y[CB-1:0], in_x[CB-1:0]};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Query point and vertex count are captured at the start of a query.
  always_ff @(posedge clk_i) begin
    if (query_start) begin
      px_q <= in_x[CB-1:0];
      py_q <= in_y[CB-1:0];
      n_q  <= n_eff;
    end
  end

  // Difference stage: A is the previous vertex, B the one just read.
  logic signed [CB-1:0] ax, ay, bx, by;
  assign ax = a_q[CB-1:0];
  assign ay = a_q[2*CB-1:CB];
  assign bx = rd_data_q[CB-1:0];
  assign by = rd_data_q[2*CB-1:CB];

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      a_q <= rd_data_q;
    end
    ux_q     <= {ax[CB-1], ax} - {px_q[CB-1], px_q};
    uy_q     <= {ay[CB-1], ay} - {py_q[CB-1], py_q};
    vx_q     <= {bx[CB-1], bx} - {px_q[CB-1], px_q};
    vy_q     <= {by[CB-1], by} - {py_q[CB-1], py_q};
    // Y span (min, max] holds the point.
    span2_q  <= (ay < by) ? (py_q > ay && py_q <= by) : (py_q > by && py_q <= ay);
    left2_q  <= (ax < bx) ? (px_q < ax) : (px_q < bx);
    right2_q <= (ax < bx) ? (px_q > bx) : (px_q > ax);
    up2_q    <= ay < by;
  end

  // Multiply stage: cross and dot product terms.
  always_ff @(posedge clk_i) begin
    pc1_q    <= PW'(ux_q * vy_q);
    pc2_q    <= PW'(uy_q * vx_q);
    pd1_q    <= PW'(ux_q * vx_q);
    pd2_q    <= PW'(uy_q * vy_q);
    span3_q  <= span2_q;
    left3_q  <= left2_q;
    right3_q <= right2_q;
    up3_q    <= up2_q;
  end

  // Sign stage: boundary test and ray crossing. Signs come from the top bits.
  logic signed [SW-1:0] cross_val, dot_val;
  logic                 on_edge, hit, side;
  assign cross_val = {pc1_q[PW-1], pc1_q} - {pc2_q[PW-1], pc2_q};
  assign dot_val   = {pd1_q[PW-1], pd1_q} + {pd2_q[PW-1], pd2_q};
  assign on_edge   = (cross_val == '0) && (dot_val[SW-1] || (dot_val == '0));
  assign side      = up3_q ? (!cross_val[SW-1] && (cross_val != '0)) : cross_val[SW-1];
  assign hit       = span3_q && (left3_q || (!right3_q && side));

  always_ff @(posedge clk_i) begin
    if (query_start) begin
      bnd_q <= 1'b0;
      par_q <= 1'b0;
    end else if (v3_q) begin
      bnd_q <= bnd_q || on_edge;
      par_q <= par_q ^ hit;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      loc_q <= bnd_q ? LocBoundary : (par_q ? LocInside : LocOutside);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataBits - LocBits){1'b0}}, loc_q};

`ifndef SYNTH
  // The edge pipeline is empty whenever a new request can be taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!v1_q && !v2_q && !v3_q))
    else $error("edge pipeline busy while idle");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("pending result overwritten");

  // The read counter never passes the vertex count of the query.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (cnt_q <= n_q))
    else $error("read counter out of range");
`endif

endmodule
